[rtl/tilt_complementary_fusion_defines.svh]
// Assertion helpers for the tilt fusion block.
`ifndef TILT_COMPLEMENTARY_FUSION_DEFINES_SVH
`define TILT_COMPLEMENTARY_FUSION_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define TCF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tcf check failed");

// Next-cycle implication.
`define TCF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tcf check failed");

`endif

[rtl/tcf_pkg.sv]
package tcf_pkg;

    localparam int CAL_SAMPLES  = 101;
    localparam int COUNT_W      = 7;
    localparam int SUM_W        = 31;
    localparam int BIAS_W       = 24;
    localparam int ANGLE_W      = 48;

    localparam int SQ_W         = 48;
    localparam int ROOT_W       = 24;
    localparam int ISQ_STEPS    = 24;

    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 48;
    localparam int CIN_W        = 25;
    localparam int Z_W          = 28;
    localparam int CSCALE       = 20;

    localparam logic signed [Z_W-1:0] PI_Q24 = 28'sd52707179;

    localparam logic [16:0] BLEND_RESET = 17'd6554;
    localparam logic [31:0] GAIN_RESET  = 32'd327860;

    localparam logic CFG_BLEND = 1'b0;
    localparam logic CFG_GAIN  = 1'b1;

    // atan(2^-i) in Q24 radians
    function automatic logic [CIN_W-1:0] atan_entry(input logic [4:0] idx);
        logic [CIN_W-1:0] v;
        case (idx)
            5'd0:    v = 25'd13176795;
            5'd1:    v = 25'd7778716;
            5'd2:    v = 25'd4110060;
            5'd3:    v = 25'd2086331;
            5'd4:    v = 25'd1047214;
            5'd5:    v = 25'd524117;
            5'd6:    v = 25'd262123;
            5'd7:    v = 25'd131069;
            5'd8:    v = 25'd65536;
            5'd9:    v = 25'd32768;
            5'd10:   v = 25'd16384;
            5'd11:   v = 25'd8192;
            5'd12:   v = 25'd4096;
            5'd13:   v = 25'd2048;
            5'd14:   v = 25'd1024;
            5'd15:   v = 25'd512;
            5'd16:   v = 25'd256;
            5'd17:   v = 25'd128;
            5'd18:   v = 25'd64;
            5'd19:   v = 25'd32;
            5'd20:   v = 25'd16;
            5'd21:   v = 25'd8;
            5'd22:   v = 25'd4;
            5'd23:   v = 25'd2;
            default: v = 25'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/tcf_isqrt.sv]
module tcf_isqrt (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start_i,
    input  logic [tcf_pkg::SQ_W-1:0]        value_i,
    output logic                            done_o,
    output logic [tcf_pkg::ROOT_W-1:0]      root_o
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [4:0]                 step_reg, step_next;
    logic [tcf_pkg::SQ_W-1:0]   v_reg, v_next;
    logic [tcf_pkg::SQ_W-1:0]   r_reg, r_next;
    logic [tcf_pkg::SQ_W-1:0]   bit_reg, bit_next;
    logic [tcf_pkg::SQ_W:0]     trial;

    // one result bit per step, from two bits of radicand
    always_comb begin
        trial     = {1'b0, r_reg} + {1'b0, bit_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        v_next    = v_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        if (start_i) begin
            busy_next = 1'b1;
            step_next = '0;
            v_next    = value_i;
            r_next    = '0;
            bit_next  = tcf_pkg::SQ_W'(1) << (2 * (tcf_pkg::ISQ_STEPS - 1));
        end else if (busy_reg) begin
            if ({1'b0, v_reg} >= trial) begin
                v_next = v_reg - trial[tcf_pkg::SQ_W-1:0];
                r_next = (r_reg >> 1) + bit_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            bit_next  = bit_reg >> 2;
            step_next = step_reg + 5'd1;
            if (step_reg == 5'(tcf_pkg::ISQ_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        v_reg    <= v_next;
        r_reg    <= r_next;
        bit_reg  <= bit_next;
    end

    assign done_o = done_reg;
    assign root_o = r_reg[tcf_pkg::ROOT_W-1:0];

endmodule

[rtl/tcf_cordic.sv]
module tcf_cordic (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start_i,
    input  logic signed [tcf_pkg::CIN_W-1:0]    y_i,
    input  logic signed [tcf_pkg::CIN_W-1:0]    x_i,
    output logic                                done_o,
    output logic signed [tcf_pkg::Z_W-1:0]      z_o
);

    logic                                   busy_reg, busy_next;
    logic                                   done_reg, done_next;
    logic [4:0]                             i_reg, i_next;
    logic signed [tcf_pkg::CORDIC_W-1:0]    x_reg, x_next;
    logic signed [tcf_pkg::CORDIC_W-1:0]    y_reg, y_next;
    logic signed [tcf_pkg::Z_W-1:0]         z_reg, z_next;
    logic signed [tcf_pkg::CORDIC_W-1:0]    xe, ye, xs, ys;
    logic signed [tcf_pkg::Z_W-1:0]         z0, at;

    always_comb begin
        xe = tcf_pkg::CORDIC_W'(x_i);
        ye = tcf_pkg::CORDIC_W'(y_i);
        z0 = '0;
        // left half-plane: rotate by pi first
        if (x_i[tcf_pkg::CIN_W-1]) begin
            xe = -xe;
            ye = -ye;
            z0 = y_i[tcf_pkg::CIN_W-1] ? -tcf_pkg::PI_Q24 : tcf_pkg::PI_Q24;
        end
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        at = $signed({3'b000, tcf_pkg::atan_entry(i_reg)});

        busy_next = busy_reg;
        done_next = 1'b0;
        i_next    = i_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start_i) begin
            z_next = z0;
            if (y_i == '0) begin
                done_next = 1'b1;
            end else begin
                busy_next = 1'b1;
                i_next    = '0;
                x_next    = xe <<< tcf_pkg::CSCALE;
                y_next    = ye <<< tcf_pkg::CSCALE;
            end
        end else if (busy_reg) begin
            if (!y_reg[tcf_pkg::CORDIC_W-1]) begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end else begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(tcf_pkg::CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        i_reg <= i_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done_o = done_reg;
    assign z_o    = z_reg;

endmodule

[rtl/tilt_complementary_fusion.sv]
// Calibration items are absorbed on acceptance and give no result; a fused item passes
// through squaring, square root, a CORDIC pass for pitch and one for roll (with no
// iterations when its y is zero), the multiply/blend steps and the output load.
// The first item after calibration first runs the bit-serial bias divide.
// Input waits until the result is loaded; a result held by m_tready stalls input.
// Reset (aresetn low, synchronous): calibration restarts; angles, blend, gain, bias default.
module tilt_complementary_fusion #(
    parameter int CALIBRATION_SAMPLES = tcf_pkg::CAL_SAMPLES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // angle_x, angle_y
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [17:0] {
        S_IDLE  = 18'd1,
        S_DIV   = 18'd2,
        S_SQY   = 18'd4,
        S_SQZ   = 18'd8,
        S_SQS   = 18'd16,
        S_SQRT  = 18'd32,
        S_PITCH = 18'd64,
        S_ROLL  = 18'd128,
        S_M1    = 18'd256,
        S_M2    = 18'd512,
        S_M3    = 18'd1024,
        S_M4    = 18'd2048,
        S_M5    = 18'd4096,
        S_M6    = 18'd8192,
        S_M7    = 18'd16384,
        S_M8    = 18'd32768,
        S_M9    = 18'd65536,
        S_OUT   = 18'd131072
    } state_t;

    localparam int SW = tcf_pkg::SUM_W;
    localparam int RW = tcf_pkg::COUNT_W + 1;
    localparam int AW = tcf_pkg::ANGLE_W;

    state_t state_reg, state_next;

    logic signed [15:0]     ax_reg, ay_reg, az_reg, ax_next, ay_next, az_next;
    logic signed [23:0]     gx_reg, gy_reg, gx_next, gy_next;
    logic [16:0]            blend_reg, blend_next;
    logic [31:0]            gain_reg, gain_next;
    logic [tcf_pkg::COUNT_W-1:0] count_reg, count_next;
    logic signed [SW-1:0]   sumx_reg, sumy_reg, sumx_next, sumy_next;
    logic                   ready_reg, ready_next;
    logic signed [tcf_pkg::BIAS_W-1:0] biasx_reg, biasy_reg, biasx_next, biasy_next;
    logic [4:0]             dstep_reg, dstep_next;
    logic [SW-1:0]          qx_reg, qy_reg, qx_next, qy_next;
    logic [RW-1:0]          rx_reg, ry_reg, rx_next, ry_next;
    logic [31:0]            sumsq_reg, sumsq_next;
    logic signed [tcf_pkg::Z_W-1:0] pz_reg, rz_reg, pz_next, rz_next;
    logic signed [17:0]     pacc_reg, racc_reg, pacc_next, racc_next;
    logic signed [AW-1:0]   angx_reg, angy_reg, angx_next, angy_next;
    logic signed [59:0]     prod_reg, prod_next;
    logic signed [51:0]     bsum_reg, bsum_next;
    logic [15:0]            resx_reg, resy_reg, resx_next, resy_next;
    logic [31:0]            mdata_reg, mdata_next;
    logic                   mvalid_reg, mvalid_next;

    logic                   s_acc, calib;
    logic signed [32:0]     mul_a, mul_b;
    logic signed [65:0]     mul_full;
    logic [16:0]            w, w_inv;
    logic signed [24:0]     dgx, dgy;
    logic signed [59:0]     rnd;
    logic [RW-1:0]          tx, ty;
    logic [SW-1:0]          qxn, qyn;

    logic                   isq_start, isq_done;
    logic [tcf_pkg::SQ_W-1:0]   isq_value;
    logic [tcf_pkg::ROOT_W-1:0] isq_root;
    logic                   cor_start, cor_done;
    logic signed [tcf_pkg::CIN_W-1:0] cor_y, cor_x;
    logic signed [tcf_pkg::Z_W-1:0]   cor_z;

    function automatic logic [15:0] blend_out(input logic signed [51:0] s);
        logic signed [51:0] t;
        logic signed [27:0] q;
        t = s + 52'sd8388608;
        q = 28'(t >>> 24);
        if (q > 28'sd32767) begin
            return 16'h7fff;
        end else if (q < -28'sd32768) begin
            return 16'h8000;
        end
        return q[15:0];
    endfunction

    function automatic logic signed [AW-1:0] angle_sat(input logic signed [AW-1:0] a,
                                                       input logic signed [59:0] p);
        logic signed [AW+9:0] s;
        s = (AW+10)'(a) + (AW+10)'(p >>> 1);
        if (s > $signed((AW+10)'({1'b0, {(AW-1){1'b1}}}))) begin
            return {1'b0, {(AW-1){1'b1}}};
        end else if (s < -$signed((AW+10)'({1'b1, {(AW-1){1'b0}}}))) begin
            return {1'b1, {(AW-1){1'b0}}};
        end
        return s[AW-1:0];
    endfunction

    assign s_tready  = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign calib     = !ready_reg && (count_reg < tcf_pkg::COUNT_W'(CALIBRATION_SAMPLES));

    assign w     = (blend_reg > 17'd65536) ? 17'd65536 : blend_reg;
    assign w_inv = 17'd65536 - w;
    assign dgx   = 25'(gx_reg) - 25'(biasx_reg);
    assign dgy   = 25'(gy_reg) - 25'(biasy_reg);

    // one shared multiplier, operands picked by state
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SQY: begin mul_a = 33'(ay_reg); mul_b = 33'(ay_reg); end
            S_SQZ: begin mul_a = 33'(az_reg); mul_b = 33'(az_reg); end
            S_M1:  begin mul_a = 33'(pz_reg); mul_b = 33'sd480875618; end
            S_M2:  begin mul_a = 33'(rz_reg); mul_b = 33'sd480875618; end
            S_M3:  begin mul_a = 33'(dgx); mul_b = $signed({1'b0, gain_reg}); end
            S_M4:  begin mul_a = 33'(dgy); mul_b = $signed({1'b0, gain_reg}); end
            S_M5:  begin mul_a = 33'(angx_reg >>> 16); mul_b = $signed({16'd0, w}); end
            S_M6:  begin mul_a = 33'(pacc_reg); mul_b = $signed({16'd0, w_inv}); end
            S_M7:  begin mul_a = 33'(angy_reg >>> 16); mul_b = $signed({16'd0, w}); end
            S_M8:  begin mul_a = 33'(racc_reg); mul_b = $signed({16'd0, w_inv}); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        mul_full = mul_a * mul_b;
    end

    assign rnd = prod_reg + (60'sd1 <<< 39);

    // restoring divide by the calibration count, one quotient bit per lane per cycle
    always_comb begin
        tx  = {rx_reg[RW-2:0], qx_reg[SW-1]};
        ty  = {ry_reg[RW-2:0], qy_reg[SW-1]};
        qxn = {qx_reg[SW-2:0], tx >= RW'(CALIBRATION_SAMPLES)};
        qyn = {qy_reg[SW-2:0], ty >= RW'(CALIBRATION_SAMPLES)};
    end

    assign isq_start = (state_reg == S_SQS);
    assign isq_value = {sumsq_reg + prod_reg[31:0], 16'd0};
    assign cor_start = ((state_reg == S_SQRT) && isq_done)
                    || ((state_reg == S_PITCH) && cor_done);
    assign cor_y = (state_reg == S_SQRT) ? 25'($signed({ax_reg, 8'd0})) : 25'(ay_reg);
    assign cor_x = (state_reg == S_SQRT) ? $signed({1'b0, isq_root}) : 25'(az_reg);

    always_comb begin
        state_next  = state_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        az_next     = az_reg;
        gx_next     = gx_reg;
        gy_next     = gy_reg;
        blend_next  = blend_reg;
        gain_next   = gain_reg;
        count_next  = count_reg;
        sumx_next   = sumx_reg;
        sumy_next   = sumy_reg;
        ready_next  = ready_reg;
        biasx_next  = biasx_reg;
        biasy_next  = biasy_reg;
        dstep_next  = dstep_reg;
        qx_next     = qx_reg;
        qy_next     = qy_reg;
        rx_next     = rx_reg;
        ry_next     = ry_reg;
        sumsq_next  = sumsq_reg;
        pz_next     = pz_reg;
        rz_next     = rz_reg;
        pacc_next   = pacc_reg;
        racc_next   = racc_reg;
        angx_next   = angx_reg;
        angy_next   = angy_reg;
        prod_next   = mul_full[59:0];
        bsum_next   = bsum_reg;
        resx_next   = resx_reg;
        resy_next   = resy_reg;
        mdata_next  = mdata_reg;
        mvalid_next = mvalid_reg && !m_tready;

        if (cfg_valid) begin
            if (cfg_index == tcf_pkg::CFG_BLEND) begin
                blend_next = cfg_data[16:0];
            end else begin
                gain_next = cfg_data;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    ax_next = s_tdata[15:0];
                    ay_next = s_tdata[31:16];
                    az_next = s_tdata[47:32];
                    gx_next = s_tdata[71:48];
                    gy_next = s_tdata[95:72];
                    if (calib) begin
                        sumx_next  = sumx_reg + SW'($signed(s_tdata[71:48]));
                        sumy_next  = sumy_reg + SW'($signed(s_tdata[95:72]));
                        count_next = count_reg + 1'b1;
                    end else if (!ready_reg) begin
                        qx_next    = sumx_reg[SW-1] ? SW'(-sumx_reg) : sumx_reg;
                        qy_next    = sumy_reg[SW-1] ? SW'(-sumy_reg) : sumy_reg;
                        rx_next    = '0;
                        ry_next    = '0;
                        dstep_next = '0;
                        state_next = S_DIV;
                    end else begin
                        state_next = S_SQY;
                    end
                end
            end
            S_DIV: begin
                qx_next    = qxn;
                qy_next    = qyn;
                rx_next    = qxn[0] ? tx - RW'(CALIBRATION_SAMPLES) : tx;
                ry_next    = qyn[0] ? ty - RW'(CALIBRATION_SAMPLES) : ty;
                dstep_next = dstep_reg + 5'd1;
                if (dstep_reg == 5'(SW - 1)) begin
                    // truncation toward zero: divide the magnitude, then restore sign
                    biasx_next = tcf_pkg::BIAS_W'(sumx_reg[SW-1] ? -qxn : qxn);
                    biasy_next = tcf_pkg::BIAS_W'(sumy_reg[SW-1] ? -qyn : qyn);
                    ready_next = 1'b1;
                    state_next = S_SQY;
                end
            end
            S_SQY:   state_next = S_SQZ;
            S_SQZ: begin
                sumsq_next = prod_reg[31:0];
                state_next = S_SQS;
            end
            S_SQS:   state_next = S_SQRT;
            S_SQRT: begin
                if (isq_done) begin
                    state_next = S_PITCH;
                end
            end
            S_PITCH: begin
                if (cor_done) begin
                    pz_next    = cor_z;
                    state_next = S_ROLL;
                end
            end
            S_ROLL: begin
                if (cor_done) begin
                    rz_next    = cor_z;
                    state_next = S_M1;
                end
            end
            S_M1:    state_next = S_M2;
            S_M2: begin
                pacc_next  = rnd[57:40];
                state_next = S_M3;
            end
            S_M3: begin
                racc_next  = rnd[57:40];
                state_next = S_M4;
            end
            S_M4: begin
                angx_next  = angle_sat(angx_reg, prod_reg);
                state_next = S_M5;
            end
            S_M5: begin
                angy_next  = angle_sat(angy_reg, prod_reg);
                state_next = S_M6;
            end
            S_M6: begin
                bsum_next  = prod_reg[51:0];
                state_next = S_M7;
            end
            S_M7: begin
                bsum_next  = bsum_reg + $signed({prod_reg[43:0], 8'd0});
                state_next = S_M8;
            end
            S_M8: begin
                resx_next  = blend_out(bsum_reg);
                bsum_next  = prod_reg[51:0];
                state_next = S_M9;
            end
            S_M9: begin
                // last product lands here; finish roll blend
                resy_next  = blend_out(bsum_reg + $signed({prod_reg[43:0], 8'd0}));
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    mdata_next  = {resy_reg, resx_reg};
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            blend_reg  <= tcf_pkg::BLEND_RESET;
            gain_reg   <= tcf_pkg::GAIN_RESET;
            count_reg  <= '0;
            sumx_reg   <= '0;
            sumy_reg   <= '0;
            ready_reg  <= 1'b0;
            biasx_reg  <= '0;
            biasy_reg  <= '0;
            angx_reg   <= '0;
            angy_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            blend_reg  <= blend_next;
            gain_reg   <= gain_next;
            count_reg  <= count_next;
            sumx_reg   <= sumx_next;
            sumy_reg   <= sumy_next;
            ready_reg  <= ready_next;
            biasx_reg  <= biasx_next;
            biasy_reg  <= biasy_next;
            angx_reg   <= angx_next;
            angy_reg   <= angy_next;
            mvalid_reg <= mvalid_next;
        end
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        az_reg    <= az_next;
        gx_reg    <= gx_next;
        gy_reg    <= gy_next;
        dstep_reg <= dstep_next;
        qx_reg    <= qx_next;
        qy_reg    <= qy_next;
        rx_reg    <= rx_next;
        ry_reg    <= ry_next;
        sumsq_reg <= sumsq_next;
        pz_reg    <= pz_next;
        rz_reg    <= rz_next;
        pacc_reg  <= pacc_next;
        racc_reg  <= racc_next;
        prod_reg  <= prod_next;
        bsum_reg  <= bsum_next;
        resx_reg  <= resx_next;
        resy_reg  <= resy_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    tcf_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (isq_start),
        .value_i (isq_value),
        .done_o  (isq_done),
        .root_o  (isq_root)
    );

    tcf_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (cor_start),
        .y_i     (cor_y),
        .x_i     (cor_x),
        .done_o  (cor_done),
        .z_o     (cor_z)
    );

`include "tilt_complementary_fusion_defines.svh"

    `TCF_ASSERT_IMP(a_div_before_ready, state_reg == S_DIV, !ready_reg)
    `TCF_ASSERT_NXT(a_calib_count, s_acc && calib, count_reg == $past(count_reg) + 1'b1)
    `TCF_ASSERT_IMP(a_no_cordic_idle, state_reg == S_IDLE, !cor_done && !isq_done)

endmodule
